@@ src/atr_pkg.sv @@
// Shared types and constants for the ADTS to RTP AAC packetizer.
// No dependencies; imported by the packetizer, its port checker and the testbench.
package atr_pkg;

  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FRAME_SAMPLES = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SEQ_START     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TS_START      = 2'd2;

  // ADTS header constants.
  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE     = 4'hF;
  localparam logic [3:0] HDR_LEN_NO_CRC  = 4'd7;
  localparam logic [3:0] HDR_LEN_CRC     = 4'd9;
  localparam logic [3:0] HDR_POS_LEN_HI  = 4'd3;
  localparam logic [3:0] HDR_POS_LEN_MID = 4'd4;
  localparam logic [3:0] HDR_POS_LEN_LO  = 4'd5;
  localparam logic [3:0] HDR_POS_FIRST   = 4'd2;

  // AU header constants: header length in bits (16) as two bytes.
  localparam logic [7:0] AU_HDR_LEN_HI = 8'h00;
  localparam logic [7:0] AU_HDR_LEN_LO = 8'h10;

  // Reset values of the configuration registers.
  localparam logic [15:0] FRAME_SAMPLES_RST = 16'd1024;
  localparam logic [15:0] SEQ_START_RST     = 16'd0;
  localparam logic [31:0] TS_START_RST      = 32'd0;

endpackage

@@ src/adts_to_rtp_aac_packetizer_unit.sv @@
// ADTS to RTP (AU header style) AAC packetizer, single module.
// Depends on atr_pkg for constants.
//
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     in_byte[7:0]
// out       out  out_valid / out_ready   out_byte, packet_end, seq_num, rtp_time
// cfg       in   cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[31:0]
//
// Each input byte is handled in the cycle it is accepted; its result beat lands in a
// two-entry output queue, so one byte per cycle flows through a payload.
// The last header byte of a good frame queues four AU header beats, which the AU
// sequencer pushes one at a time, as the queue has room, while input is held off.
// Input is also held off while both output queue entries are full.
// Reset (rst, synchronous) empties the queue and returns to syncword hunting.
// The configuration port is always ready.
module adts_to_rtp_aac_packetizer_unit
  import atr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 packet_end,
  output logic [15:0]          seq_num,
  output logic [31:0]          rtp_time,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] seq;
    logic [31:0] ts;
  } beat_t;

  // Parser state.
  phase_t      phase, phase_next;
  logic        prev_was_ff, prev_was_ff_next;
  logic [3:0]  header_pos, header_pos_next;
  logic [3:0]  header_len, header_len_next;
  logic [12:0] frame_length, frame_length_next;
  logic [12:0] bytes_left, bytes_left_next;
  logic [15:0] seq_counter, seq_counter_next;
  logic [31:0] ts_counter, ts_counter_next;
  logic [15:0] frame_samples;

  // AU header sequencer.
  logic [2:0]  au_cnt, au_cnt_next;
  logic [12:0] au_size;

  // Output queue.
  beat_t       q0, q1;
  logic [1:0]  cnt;
  logic        pop, push, wr_slot;
  beat_t       push_beat, prod_beat, au_beat;
  logic        prod_valid, start_au;

  logic        in_fire;
  logic [12:0] fl;
  logic [3:0]  pos_inc;
  logic [12:0] bl_dec;

  assign cfg_ready = 1'b1;
  assign in_ready  = (au_cnt == 3'd0) && (cnt != 2'd2);
  assign in_fire   = in_valid && in_ready;

  assign out_valid  = (cnt != 2'd0);
  assign out_byte   = q0.data;
  assign packet_end = q0.last;
  assign seq_num    = q0.seq;
  assign rtp_time   = q0.ts;

  always_comb begin
    phase_next        = phase;
    prev_was_ff_next  = prev_was_ff;
    header_pos_next   = header_pos;
    header_len_next   = header_len;
    frame_length_next = frame_length;
    bytes_left_next   = bytes_left;
    seq_counter_next  = seq_counter;
    ts_counter_next   = ts_counter;
    prod_valid        = 1'b0;
    prod_beat         = '0;
    start_au          = 1'b0;
    fl                = frame_length;
    pos_inc           = header_pos + 4'd1;
    bl_dec            = bytes_left - 13'd1;
    if (in_fire) begin
      unique case (phase)
        PH_HEADER: begin
          if (header_pos == HDR_POS_LEN_HI) begin
            fl = {in_byte[1:0], 11'd0};
          end else if (header_pos == HDR_POS_LEN_MID) begin
            fl = frame_length | {2'd0, in_byte, 3'd0};
          end else if (header_pos == HDR_POS_LEN_LO) begin
            fl = frame_length | {10'd0, in_byte[7:5]};
          end
          frame_length_next = fl;
          if (pos_inc >= header_len) begin
            header_pos_next  = 4'd0;
            prev_was_ff_next = 1'b0;
            // A frame length that does not cover more than the header is dropped.
            if (fl <= {9'd0, header_len}) begin
              phase_next = PH_HUNT;
            end else begin
              bytes_left_next = fl - {9'd0, header_len};
              phase_next      = PH_PAYLOAD;
              start_au        = 1'b1;
            end
          end else begin
            header_pos_next = pos_inc;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = bl_dec;
          prod_valid      = 1'b1;
          prod_beat.data  = in_byte;
          if (bl_dec == 13'd0) begin
            seq_counter_next = seq_counter + 16'd1;
            ts_counter_next  = ts_counter + {16'd0, frame_samples};
            phase_next       = PH_HUNT;
            prev_was_ff_next = 1'b0;
            prod_beat.last   = 1'b1;
            prod_beat.seq    = seq_counter_next;
            prod_beat.ts     = ts_counter_next;
          end
        end
        default: begin
          // Hunting; the unused phase code behaves the same way.
          if (prev_was_ff && (in_byte[7:4] == SYNC_NIBBLE)) begin
            if (header_len == 4'd0) begin
              header_len_next = in_byte[0] ? HDR_LEN_NO_CRC : HDR_LEN_CRC;
            end
            header_pos_next   = HDR_POS_FIRST;
            frame_length_next = 13'd0;
            prev_was_ff_next  = 1'b0;
            phase_next        = PH_HEADER;
          end else begin
            phase_next       = PH_HUNT;
            prev_was_ff_next = (in_byte == SYNC_BYTE);
          end
        end
      endcase
    end
  end

  // AU header beats in order: length high, length low, size high, size low with index.
  always_comb begin
    au_beat = '0;
    case (au_cnt)
      3'd4:    au_beat.data = AU_HDR_LEN_HI;
      3'd3:    au_beat.data = AU_HDR_LEN_LO;
      3'd2:    au_beat.data = au_size[12:5];
      default: au_beat.data = {au_size[4:0], 3'd0};
    endcase
  end

  always_comb begin
    au_cnt_next = au_cnt;
    push        = 1'b0;
    push_beat   = prod_beat;
    if ((au_cnt != 3'd0) && (cnt != 2'd2)) begin
      push        = 1'b1;
      push_beat   = au_beat;
      au_cnt_next = au_cnt - 3'd1;
    end else if (prod_valid) begin
      push = 1'b1;
    end
    if (start_au) begin
      au_cnt_next = 3'd4;
    end
  end

  assign pop     = out_valid && out_ready;
  assign wr_slot = pop ? (cnt[1:0] == 2'd2) : (cnt[1:0] == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      prev_was_ff   <= 1'b0;
      header_pos    <= 4'd0;
      header_len    <= 4'd0;
      frame_length  <= 13'd0;
      bytes_left    <= 13'd0;
      seq_counter   <= SEQ_START_RST;
      ts_counter    <= TS_START_RST;
      frame_samples <= FRAME_SAMPLES_RST;
      au_cnt        <= 3'd0;
      cnt           <= 2'd0;
    end else begin
      phase        <= phase_next;
      prev_was_ff  <= prev_was_ff_next;
      header_pos   <= header_pos_next;
      header_len   <= header_len_next;
      frame_length <= frame_length_next;
      bytes_left   <= bytes_left_next;
      seq_counter  <= seq_counter_next;
      ts_counter   <= ts_counter_next;
      au_cnt       <= au_cnt_next;
      cnt          <= cnt + {1'b0, push} - {1'b0, pop};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FRAME_SAMPLES: frame_samples <= cfg_data[15:0];
          REG_SEQ_START:     seq_counter   <= cfg_data[15:0];
          REG_TS_START:      ts_counter    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (start_au) begin
      au_size <= bytes_left_next;
    end
    // A beat pushed into an otherwise emptying queue goes straight to the head.
    if (push && !wr_slot) begin
      q0 <= push_beat;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && wr_slot) begin
      q1 <= push_beat;
    end
  end

endmodule

@@ src/atr_port_checker.sv @@
// Port-level checker for the packetizer, attached by the bind below.
// Depends on atr_pkg for the configuration index width.
module atr_port_checker
  import atr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_byte,
  input logic               packet_end,
  input logic [15:0]        seq_num,
  input logic [31:0]        rtp_time,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [CfgIdxW-1:0] cfg_index,
  input logic [31:0]        cfg_data
);

  // The output is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Beats that do not close a packet carry no sequence number or timestamp.
  a_mid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !packet_end) |-> ((seq_num == 16'd0) && (rtp_time == 32'd0)))
    else $error("non-final beat carries sequence or timestamp");

  // Every packet opens with AU header beats, so two packet ends never follow each other.
  a_no_double_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && packet_end) |=> !(out_valid && packet_end))
    else $error("packet end directly after packet end");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(packet_end)))
    else $error("stalled output beat changed");

endmodule

bind adts_to_rtp_aac_packetizer_unit atr_port_checker u_atr_port_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .packet_end (packet_end),
  .seq_num    (seq_num),
  .rtp_time   (rtp_time),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);

@@ test/adts_to_rtp_aac_packetizer_unit_tb.sv @@
// Self-checking testbench for adts_to_rtp_aac_packetizer_unit: ADTS byte streams in,
// AU header and payload beats out, checked against an in-bench packetizer model.
// Depends on atr_pkg and the packetizer RTL only.
`timescale 1ns / 1ps

module adts_to_rtp_aac_packetizer_unit_tb;
  import atr_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_PRINTED    = 30;

  typedef enum logic [1:0] {SCAN_SYNC, SCAN_HEADER, SCAN_PAYLOAD} scan_phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] seq;
    logic [31:0] ts;
  } au_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte;
  logic                packet_end;
  logic [15:0]         seq_num;
  logic [31:0]         rtp_time;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  adts_to_rtp_aac_packetizer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .seq_num    (seq_num),
    .rtp_time   (rtp_time),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Packetizer model state, starting from the reset values.
  scan_phase_t  scan_phase = SCAN_SYNC;
  logic         saw_ff     = 1'b0;
  logic [3:0]   hdr_pos    = '0;
  logic [3:0]   hdr_len    = '0;
  logic [12:0]  adts_len   = '0;
  logic [12:0]  bytes_left = '0;
  logic [15:0]  samples    = FRAME_SAMPLES_RST;
  logic [15:0]  seq_ctr    = SEQ_START_RST;
  logic [31:0]  ts_ctr     = TS_START_RST;

  logic [7:0]   adts_bytes_q[$];
  au_beat_t     payload_beats_q[$];

  logic         first_prot;
  logic [3:0]   hdr_bytes;
  logic         in_gaps_on    = 1'b0;
  logic         out_stalls_on = 1'b0;
  int unsigned  hold_epoch    = 0;
  int unsigned  hold_seen     = 0;
  int unsigned  out_hold      = 0;
  int unsigned  out_gap       = 0;
  int unsigned  in_gap        = 0;
  int unsigned  idle_cycles   = 0;
  int unsigned  stream_items  = 0;
  int unsigned  bytes_sent    = 0;
  int unsigned  beats_checked = 0;
  int unsigned  packets_seen  = 0;
  int unsigned  errors        = 0;

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] mismatch on %s at beat %0d: got %0h, expected %0h",
               $realtime, what, beats_checked, got, want);
    end
  endtask

  function automatic void note_beat(input logic [7:0] b, input logic last,
                                    input logic [15:0] seq, input logic [31:0] ts);
    au_beat_t beat;
    beat.data = b;
    beat.last = last;
    beat.seq  = seq;
    beat.ts   = ts;
    payload_beats_q.push_back(beat);
  endfunction

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    case (idx)
      REG_FRAME_SAMPLES: samples = value[15:0];
      REG_SEQ_START:     seq_ctr = value[15:0];
      REG_TS_START:      ts_ctr  = value;
      default: ;
    endcase
  endtask

  // Advances the model by one stream byte and queues the beats it produces.
  task automatic packetize_byte(input logic [7:0] b);
    case (scan_phase)
      SCAN_HEADER: begin
        if (hdr_pos == HDR_POS_LEN_HI) adts_len = {b[1:0], 11'd0};
        else if (hdr_pos == HDR_POS_LEN_MID) adts_len = adts_len | {2'b00, b, 3'b000};
        else if (hdr_pos == HDR_POS_LEN_LO) adts_len = adts_len | {10'd0, b[7:5]};
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos >= hdr_len) begin
          hdr_pos = '0;
          saw_ff  = 1'b0;
          if (adts_len <= {9'd0, hdr_len}) begin
            scan_phase = SCAN_SYNC;
          end else begin
            bytes_left = adts_len - {9'd0, hdr_len};
            scan_phase = SCAN_PAYLOAD;
            note_beat(AU_HDR_LEN_HI, 1'b0, '0, '0);
            note_beat(AU_HDR_LEN_LO, 1'b0, '0, '0);
            note_beat(bytes_left[12:5], 1'b0, '0, '0);
            note_beat({bytes_left[4:0], 3'b000}, 1'b0, '0, '0);
          end
        end
      end
      SCAN_PAYLOAD: begin
        bytes_left = bytes_left - 13'd1;
        if (bytes_left == '0) begin
          seq_ctr    = seq_ctr + 16'd1;
          ts_ctr     = ts_ctr + {16'd0, samples};
          scan_phase = SCAN_SYNC;
          saw_ff     = 1'b0;
          note_beat(b, 1'b1, seq_ctr, ts_ctr);
        end else begin
          note_beat(b, 1'b0, '0, '0);
        end
      end
      default: begin
        if (saw_ff && b[7:4] == SYNC_NIBBLE) begin
          // The header length is taken from the first frame only.
          if (hdr_len == '0) hdr_len = b[0] ? HDR_LEN_NO_CRC : HDR_LEN_CRC;
          hdr_pos    = HDR_POS_FIRST;
          adts_len   = '0;
          saw_ff     = 1'b0;
          scan_phase = SCAN_HEADER;
        end else begin
          scan_phase = SCAN_SYNC;
          saw_ff     = (b == SYNC_BYTE);
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    adts_bytes_q.push_back(b);
    stream_items++;
  endtask

  task automatic queue_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Emits one ADTS header of the latched length with random filler bits.
  task automatic queue_header(input logic prot, input logic [12:0] len);
    logic [7:0] hb [0:8];
    hb[0] = SYNC_BYTE;
    hb[1] = {SYNC_NIBBLE, 3'($urandom_range(0, 7)), prot};
    hb[2] = 8'($urandom_range(0, 255));
    hb[3] = {6'($urandom_range(0, 63)), len[12:11]};
    hb[4] = len[10:3];
    hb[5] = {len[2:0], 5'($urandom_range(0, 31))};
    hb[6] = 8'($urandom_range(0, 255));
    hb[7] = 8'($urandom_range(0, 255));
    hb[8] = 8'($urandom_range(0, 255));
    for (int i = 0; i < hdr_bytes; i++) send_byte(hb[i]);
  endtask

  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned pay;
    stop_at = stream_items + n_items;
    while (stream_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 90) pay = $urandom_range(1, 16);
        else pay = $urandom_range(17, 40);
        queue_header(1'($urandom_range(0, 1)), 13'(hdr_bytes + pay));
        queue_payload(pay);
      end else if (r < 87) begin
        // A length that does not cover the header drops the frame.
        queue_header(1'($urandom_range(0, 1)), 13'($urandom_range(0, hdr_bytes)));
      end else if (r < 97) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 254)));
        if ($urandom_range(0, 1)) begin
          send_byte(SYNC_BYTE);
          send_byte(8'($urandom_range(0, 8'hEF)));
        end
      end else begin
        // The frame claims more bytes than it carries, so the next frame is eaten.
        pay = $urandom_range(1, 20);
        queue_header(1'($urandom_range(0, 1)),
                     13'(hdr_bytes + pay + $urandom_range(1, 3)));
        queue_payload(pay);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, value);
  endtask

  // Waits until every queued byte has been taken and every expected beat seen.
  task automatic wait_drained(input int unsigned settle);
    while (bytes_sent < stream_items || payload_beats_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  // Stream driver: one byte beat at a time from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        packetize_byte(in_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (adts_bytes_q.size() > 0) begin
          in_byte  <= adts_bytes_q.pop_front();
          in_valid <= 1'b1;
          if (in_gaps_on) in_gap = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with its own backpressure.
  always @(posedge clk) begin
    au_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (payload_beats_q.size() == 0) begin
          report_mismatch("out_byte, no beat expected", 32'(out_byte), '0);
        end else begin
          want = payload_beats_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
          if (packet_end !== want.last)
            report_mismatch("packet_end", 32'(packet_end), 32'(want.last));
          if (seq_num !== want.seq)
            report_mismatch("seq_num", 32'(seq_num), 32'(want.seq));
          if (rtp_time !== want.ts) report_mismatch("rtp_time", rtp_time, want.ts);
        end
        beats_checked++;
        if (packet_end) packets_seen++;
      end
      if (hold_seen != hold_epoch) begin
        hold_seen = hold_epoch;
        out_hold  = HOLD_CYCLES;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on) out_gap = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles, %0d beats still expected",
                 $realtime, idle_cycles, payload_beats_q.size());
        $display("FAIL adts_to_rtp_aac_packetizer_unit");
        $finish;
      end
    end
  end

  initial begin
    first_prot = 1'($urandom_range(0, 1));
    hdr_bytes  = first_prot ? HDR_LEN_NO_CRC : HDR_LEN_CRC;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset register values, noise without a syncword, a short frame
    // carrying the byte extremes, then a frame with the other protection bit
    // whose length only covers the header.
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(8'hEF);
    queue_header(first_prot, 13'(hdr_bytes + 4'd2));
    send_byte(8'h00);
    send_byte(8'hFF);
    queue_header(!first_prot, {9'd0, hdr_bytes});
    wait_drained(8);

    // Counters one step from wrapping, zero samples per frame, no idling.
    write_reg(REG_FRAME_SAMPLES, 32'h0000_0000);
    write_reg(REG_SEQ_START, 32'h0000_FFFF);
    write_reg(REG_TS_START, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, $urandom);
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    queue_random_traffic(38);
    wait_drained(8);

    // Largest sample count and a long receiver hold-off while bytes keep coming.
    write_reg(REG_FRAME_SAMPLES, 32'h0000_FFFF);
    write_reg(REG_SEQ_START, 32'h0000_FFFE);
    write_reg(REG_TS_START, 32'hFFFE_0001);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    queue_random_traffic(38);
    hold_epoch++;
    wait_drained(8);

    // Random counters, upper data bits set on the narrow registers, and the
    // header of a frame of the largest length followed by a few of its bytes.
    write_reg(REG_FRAME_SAMPLES, {16'hFFFF, 16'd1});
    write_reg(REG_SEQ_START, $urandom);
    write_reg(REG_TS_START, $urandom);
    out_stalls_on = 1'b0;
    queue_random_traffic(38);
    // Zero bytes finish any frame still claiming bytes and clear a pending 0xFF.
    repeat (3) send_byte(8'h00);
    queue_header(1'b0, 13'h1FFF);
    queue_payload(6);
    wait_drained(20);

    if (payload_beats_q.size() != 0) begin
      report_mismatch("beats never delivered", 32'(payload_beats_q.size()), '0);
    end
    $display("Sent %0d stream bytes with %0d-byte headers; checked %0d beats in %0d packets.",
             bytes_sent, hdr_bytes, beats_checked, packets_seen);
    $display("Four register settings, counter wrap, dropped and truncated frames, %0d errors.",
             errors);
    if (errors == 0) begin
      $display("PASS adts_to_rtp_aac_packetizer_unit");
    end else begin
      $display("FAIL adts_to_rtp_aac_packetizer_unit");
    end
    $finish;
  end

endmodule
